>>> rtl/core/fprzs_pkg.sv
// ============================================================================
// fprzs_pkg
// Types, constants and the divider step shared by the zero-safe reciprocal.
// ============================================================================
package fprzs_pkg;

  // Significand width in double format, hidden bit included.
  localparam int MANT_W = 53;
  // Partial remainder width; it stays below twice the divisor.
  localparam int REM_W  = MANT_W + 1;
  // Quotient bits: integer bit, 55 fraction bits and one spare bit.
  localparam int QUO_W  = 57;
  // Normalized quotient width handed to rounding.
  localparam int FRAC_W = QUO_W + 1;
  // Signed exponent width, covers results down to double denormals.
  localparam int EXP_W  = 13;

  localparam logic [63:0] DP_QUIET = 64'h0008_0000_0000_0000;
  localparam logic [31:0] SP_QUIET = 32'h0040_0000;

  localparam logic signed [EXP_W-1:0] DP_BIAS  = 13'sd1023;
  localparam logic signed [EXP_W-1:0] SP_BIAS  = 13'sd127;
  localparam logic signed [EXP_W-1:0] DP_EMIN  = -13'sd1022;
  localparam logic signed [EXP_W-1:0] SP_EMIN  = -13'sd126;

  // Precision codes of the mode register.
  localparam logic MODE_SP = 1'b0;
  localparam logic MODE_DP = 1'b1;

  // One stage of the front end and divider pipeline.
  typedef struct packed {
    logic                    vld;
    logic                    mode;
    logic                    last;
    logic                    sign;
    logic                    spec;
    logic [63:0]             spec_bits;
    logic signed [EXP_W-1:0] expo;
    logic [5:0]              lz;
    logic [MANT_W-1:0]       mant;
    logic [REM_W-1:0]        rem;
    logic [QUO_W-1:0]        quo;
  } pipe_t;

  // One restoring division step: one quotient bit per stage.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t n;
    logic  ge;
    n  = p;
    ge = (p.rem >= {1'b0, p.mant});
    if (ge) begin
      n.rem = (p.rem - {1'b0, p.mant}) << 1;
    end else begin
      n.rem = p.rem << 1;
    end
    n.quo = {p.quo[QUO_W-2:0], ge};
    return n;
  endfunction

endpackage

>>> rtl/core/fp_reciprocal_zero_safe.sv
// ============================================================================
// fp_reciprocal_zero_safe
// Pipelined IEEE-754 reciprocal, single or double precision, round to
// nearest-even, with zero inputs passed through unchanged.
// ============================================================================
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_operand_bits,    | into block
//          | in_last_item                            |
//  out     | out_valid, out_stall, out_result_bits,  | out of block
//          | out_last_result                         |
//  cfg     | cfg_we, cfg_precision_mode              | into block
//
// One beat enters per cycle unless out_stall holds the output; there are two
// unpack and normalize stages, 57 stages of the bit-per-stage divider, one
// rounding stage and the output register. The divider depth sets the latency.
// Reset (rst_n low, synchronous) empties the pipeline and selects single
// precision. When the output beat is held by out_stall the whole pipeline
// freezes and in_stall is raised; bubbles move on while the output is free.
module fp_reciprocal_zero_safe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_precision_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand_bits,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_bits,
  output logic        out_last_result
);
  import fprzs_pkg::*;

  localparam int STEPS = QUO_W;

  logic        mode_r;
  logic        en;
  pipe_t       p1_nxt, p1_r, p2_nxt, p2_r;
  pipe_t       div_r [0:STEPS-1];
  logic        out_valid_r;
  logic [63:0] out_bits_r;
  logic        out_last_r;

  // Rounding stage registers.
  logic                    r1_vld_r, r1_mode_r, r1_last_r, r1_sign_r;
  logic                    r1_spec_r, r1_ovf_r, r1_rup_r;
  logic [63:0]             r1_spec_bits_r;
  logic [MANT_W-1:0]       r1_keep_r;
  logic [10:0]             r1_base_r;
  logic [MANT_W-1:0]       r1_keep_nxt;
  logic                    r1_rup_nxt, r1_ovf_nxt;
  logic [10:0]             r1_base_nxt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SP;
    end else if (cfg_we) begin
      mode_r <= cfg_precision_mode;
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Unpack and classify the operand, find the leading zero count.
  always_comb begin
    logic [10:0] e_fld;
    logic        all_ones, is_zero, frac_nz;
    p1_nxt      = '0;
    p1_nxt.vld  = in_valid;
    p1_nxt.mode = mode_r;
    p1_nxt.last = in_last_item;
    if (mode_r == MODE_DP) begin
      e_fld         = in_operand_bits[62:52];
      all_ones      = (e_fld == 11'h7FF);
      frac_nz       = (in_operand_bits[51:0] != '0);
      is_zero       = (in_operand_bits[62:0] == '0);
      p1_nxt.sign   = in_operand_bits[63];
      p1_nxt.mant   = {(e_fld != '0), in_operand_bits[51:0]};
      p1_nxt.expo   = ((e_fld == '0) ? 13'sd1 : $signed({2'b0, e_fld})) - DP_BIAS;
      if (is_zero) begin
        p1_nxt.spec_bits = in_operand_bits;
      end else if (frac_nz) begin
        p1_nxt.spec_bits = in_operand_bits | DP_QUIET;
      end else begin
        p1_nxt.spec_bits = {in_operand_bits[63], 63'b0};
      end
    end else begin
      e_fld         = {3'b0, in_operand_bits[30:23]};
      all_ones      = (in_operand_bits[30:23] == 8'hFF);
      frac_nz       = (in_operand_bits[22:0] != '0);
      is_zero       = (in_operand_bits[30:0] == '0);
      p1_nxt.sign   = in_operand_bits[31];
      p1_nxt.mant   = {(e_fld != '0), in_operand_bits[22:0], 29'b0};
      p1_nxt.expo   = ((e_fld == '0) ? 13'sd1 : $signed({2'b0, e_fld})) - SP_BIAS;
      if (is_zero) begin
        p1_nxt.spec_bits = {32'b0, in_operand_bits[31:0]};
      end else if (frac_nz) begin
        p1_nxt.spec_bits = {32'b0, in_operand_bits[31:0] | SP_QUIET};
      end else begin
        p1_nxt.spec_bits = {32'b0, in_operand_bits[31], 31'b0};
      end
    end
    p1_nxt.spec = is_zero || all_ones;
    // Priority encoder: the highest set bit wins.
    for (int i = 0; i < MANT_W; i++) begin
      if (p1_nxt.mant[i]) begin
        p1_nxt.lz = 6'(MANT_W - 1 - i);
      end
    end
  end

  // Normalize denormals and seed the divider with a dividend of one.
  always_comb begin
    p2_nxt      = p1_r;
    p2_nxt.mant = p1_r.mant << p1_r.lz;
    p2_nxt.expo = p1_r.expo - $signed({7'b0, p1_r.lz});
    p2_nxt.rem  = REM_W'(1) << (MANT_W - 1);
    p2_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.vld <= 1'b0;
      p2_r.vld <= 1'b0;
    end else if (en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
  end

  // Divider: one quotient bit per stage.
  for (genvar g = 0; g < STEPS; g++) begin : g_div
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_r[g].vld <= 1'b0;
        end else if (en) begin
          div_r[g] <= div_step(p2_r);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_r[g].vld <= 1'b0;
        end else if (en) begin
          div_r[g] <= div_step(div_r[g-1]);
        end
      end
    end
  end

  // Normalize the quotient, align for denormal results and decide rounding.
  always_comb begin
    pipe_t                   d;
    logic                    q0, st, st2, g_bit, s_bit;
    logic [FRAC_W-1:0]       f, fs, mask;
    logic signed [EXP_W-1:0] e_r, emin, emax, bias, dd, be;
    logic [1:0]              sh;
    d    = div_r[STEPS-1];
    q0   = d.quo[QUO_W-1];
    st   = (d.rem != '0);
    f    = q0 ? {d.quo, 1'b0} : {d.quo[QUO_W-2:0], 2'b0};
    e_r  = -d.expo - (q0 ? 13'sd0 : 13'sd1);
    emin = (d.mode == MODE_DP) ? DP_EMIN : SP_EMIN;
    emax = (d.mode == MODE_DP) ? DP_BIAS : SP_BIAS;
    bias = (d.mode == MODE_DP) ? DP_BIAS : SP_BIAS;
    dd   = emin - e_r;
    if (dd <= 13'sd0) begin
      sh = 2'd0;
    end else if (dd >= 13'sd3) begin
      sh = 2'd3;
    end else begin
      sh = dd[1:0];
    end
    mask = (FRAC_W'(1) << sh) - FRAC_W'(1);
    st2  = st || ((f & mask) != '0);
    fs   = f >> sh;
    if (d.mode == MODE_DP) begin
      r1_keep_nxt = fs[FRAC_W-1:5];
      g_bit       = fs[4];
      s_bit       = st2 || (fs[3:0] != '0);
    end else begin
      r1_keep_nxt = {29'b0, fs[FRAC_W-1:34]};
      g_bit       = fs[33];
      s_bit       = st2 || (fs[32:0] != '0);
    end
    r1_rup_nxt  = g_bit && (s_bit || r1_keep_nxt[0]);
    r1_ovf_nxt  = (e_r > emax);
    be          = e_r + bias - 13'sd1;
    r1_base_nxt = (sh != 2'd0) ? 11'd0 : be[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
    end else if (en) begin
      r1_vld_r <= div_r[STEPS-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_mode_r      <= div_r[STEPS-1].mode;
      r1_last_r      <= div_r[STEPS-1].last;
      r1_sign_r      <= div_r[STEPS-1].sign;
      r1_spec_r      <= div_r[STEPS-1].spec;
      r1_spec_bits_r <= div_r[STEPS-1].spec_bits;
      r1_keep_r      <= r1_keep_nxt;
      r1_rup_r       <= r1_rup_nxt;
      r1_ovf_r       <= r1_ovf_nxt;
      r1_base_r      <= r1_base_nxt;
    end
  end

  // Pack: the hidden bit and any rounding carry ripple into the exponent.
  logic [63:0] res_nxt;
  always_comb begin
    logic [62:0] mag_dp;
    logic [30:0] mag_sp;
    mag_dp = {r1_base_r, 52'b0} + {10'b0, r1_keep_r} + {62'b0, r1_rup_r};
    mag_sp = {r1_base_r[7:0], 23'b0} + {7'b0, r1_keep_r[23:0]} + {30'b0, r1_rup_r};
    if (r1_spec_r) begin
      res_nxt = r1_spec_bits_r;
    end else if (r1_mode_r == MODE_DP) begin
      res_nxt = r1_ovf_r ? {r1_sign_r, 11'h7FF, 52'b0} : {r1_sign_r, mag_dp};
    end else begin
      res_nxt = r1_ovf_r ? {32'b0, r1_sign_r, 8'hFF, 23'b0} : {32'b0, r1_sign_r, mag_sp};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= r1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bits_r <= res_nxt;
      out_last_r <= r1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_bits_r;
  assign out_last_result = out_last_r;

endmodule

>>> bench/fp_reciprocal_zero_safe_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the zero-safe floating-point reciprocal
// Streams single- and double-precision operands through the block and checks
// every output beat against a bit-exact reciprocal predictor built on integer
// long division with round-to-nearest-even. Both channels idle in random
// bursts; the precision register is switched between phases.
// ----------------------------------------------------------------------------
module fp_reciprocal_zero_safe_tb;
  import fprzs_pkg::*;

  // Expected reciprocals of accepted operands, oldest first.
  class recip_scoreboard;
    logic [64:0] expected_q[$];
    logic        mode;
    int          errors;

    function new();
      mode   = MODE_SP;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Bit-exact reciprocal of one operand in the selected precision.
    static function logic [63:0] reciprocal_of(logic dp, logic [63:0] op);
      int           ew, mw, bias, ex, t, er, emin, sh;
      logic [63:0]  x, sgn, mag, e, m;
      logic [127:0] sig, num, q, r, kept, pack, expmask;
      logic         rb, stk;
      if (dp == MODE_DP) begin
        ew = 11; mw = 52; bias = 1023; x = op;
      end else begin
        ew = 8; mw = 23; bias = 127; x = {32'b0, op[31:0]};
      end
      sgn     = x & (64'd1 << (ew + mw));
      mag     = x & ((64'd1 << (ew + mw)) - 1);
      e       = (x >> mw) & ((64'd1 << ew) - 1);
      m       = x & ((64'd1 << mw) - 1);
      expmask = ((128'd1 << ew) - 1) << mw;
      // Zeros pass unchanged; NaNs are quieted; infinities give a signed zero.
      if (mag == 0) return x;
      if (e == (64'd1 << ew) - 1) begin
        if (m != 0) return x | (64'd1 << (mw - 1));
        return sgn;
      end
      // Normalize the significand, denormals included.
      if (e == 0) begin
        sig = 128'(m);
        ex  = 1 - bias;
        while (!sig[mw]) begin
          sig = sig << 1;
          ex--;
        end
      end else begin
        sig = 128'(m) | (128'd1 << mw);
        ex  = int'(e) - bias;
      end
      num = 128'd1 << (2 * mw + 3);
      q   = num / sig;
      r   = num % sig;
      t   = q[mw + 3] ? mw + 3 : mw + 2;
      er  = t + mw - ex - (2 * mw + 3);
      emin = 1 - bias;
      sh  = t - mw;
      if (er < emin) begin
        sh = sh + emin - er;
        er = emin;
      end
      // Round to nearest-even on the guard bit and everything below it.
      if (sh > 120) begin
        kept = 0;
        rb   = 1'b0;
      end else begin
        kept = q >> sh;
        rb   = q[sh - 1];
        stk  = ((q & ((128'd1 << (sh - 1)) - 1)) != 0) || (r != 0);
        if (rb && (stk || kept[0])) kept = kept + 1;
      end
      // The hidden bit carries into the exponent field; overflow saturates.
      pack = (128'(er + bias - 1) << mw) + kept;
      if (pack >= expmask) pack = expmask;
      return sgn | pack[63:0];
    endfunction

    function void note_beat(logic [63:0] op, logic last);
      expected_q.push_back({last, reciprocal_of(mode, op)});
    endfunction

    task check_beat(logic [63:0] bits, logic last);
      logic [64:0] exp_beat;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat %h", bits));
        return;
      end
      exp_beat = expected_q.pop_front();
      if (bits !== exp_beat[63:0])
        report($sformatf("result %h, wanted %h", bits, exp_beat[63:0]));
      if (last !== exp_beat[64])
        report($sformatf("last %b, wanted %b", last, exp_beat[64]));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_precision_mode;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_operand_bits;
  logic        in_last_item;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_result_bits;
  logic        out_last_result;

  recip_scoreboard sb;
  bit              quiet;
  int              stall_left;
  int              cycles = 0;

  localparam int DRAIN_CYCLES = 70;
  localparam int CYCLE_LIMIT  = 400000;

  fp_reciprocal_zero_safe dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_precision_mode (cfg_precision_mode),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operand_bits    (in_operand_bits),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_bits    (out_result_bits),
    .out_last_result    (out_last_result)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Output side: check accepted beats and stall in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) sb.check_beat(out_result_bits, out_last_result);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one beat, possibly after a gap, and hold it until accepted.
  task drive_beat(logic [63:0] op, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= op;
    in_last_item    <= last;
    do @(posedge clk); while (in_stall);
    sb.note_beat(op, last);
  endtask

  // Let the pipeline empty, then change the precision register.
  task write_mode(logic m);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we             <= 1'b1;
    cfg_precision_mode <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  // Random operand biased toward zeros, infinities, NaNs and extreme exponents.
  function automatic logic [63:0] random_operand(logic dp);
    int          ew, mw;
    logic [63:0] s, e, m, emax, val;
    ew   = (dp == MODE_DP) ? 11 : 8;
    mw   = (dp == MODE_DP) ? 52 : 23;
    emax = (64'd1 << ew) - 1;
    s    = 64'($urandom_range(0, 1));
    e    = {$urandom, $urandom} & emax;
    m    = {$urandom, $urandom} & ((64'd1 << mw) - 1);
    case ($urandom_range(0, 11))
      0, 1, 2, 3: ;
      4: begin e = 0; m = 0; end
      5: begin e = emax; m = 0; end
      6: begin e = emax; if (m == 0) m = 1; end
      7: e = 0;
      8: e = 64'($urandom_range(0, 3));
      9: e = emax - 64'($urandom_range(1, 3));
      10: m = 0;
      default: m = (64'd1 << mw) - 1 - 64'($urandom_range(0, 3));
    endcase
    val = (s << (ew + mw)) | (e << mw) | m;
    if (dp == MODE_SP) val[63:32] = $urandom;
    return val;
  endfunction

  logic [63:0] sp_directed[13] = '{
    64'h0000_0000_0000_0000, 64'hDEAD_BEEF_8000_0000, 64'h0000_0000_7F80_0000,
    64'h0000_0000_FF80_0000, 64'h0000_0000_7FC0_0001, 64'h0000_0000_FF80_0123,
    64'h0000_0000_3F80_0000, 64'h0000_0000_FF7F_FFFF, 64'h0000_0000_0000_0001,
    64'h0000_0000_807F_FFFF, 64'h0000_0000_0080_0000, 64'h0000_0000_4040_0000,
    64'hA5A5_A5A5_3F00_0000
  };
  logic [63:0] dp_directed[12] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
    64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0123,
    64'h3FF0_0000_0000_0000, 64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
    64'h800F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000, 64'h4008_0000_0000_0000
  };

  // Main sequence: directed operands per precision, then random phases.
  initial begin
    logic cur;
    sb                 = new();
    quiet              = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_precision_mode = MODE_SP;
    in_valid           = 1'b0;
    in_operand_bits    = '0;
    in_last_item       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_SP);
    foreach (sp_directed[i]) drive_beat(sp_directed[i], i[0]);
    write_mode(MODE_DP);
    foreach (dp_directed[i]) drive_beat(dp_directed[i], i[0]);

    // Random phases alternate the precision; the last one runs without idling.
    for (int ph = 0; ph < 6; ph++) begin
      cur = ph[0] ? MODE_DP : MODE_SP;
      write_mode(cur);
      if (ph == 5) quiet = 1'b1;
      repeat (255) drive_beat(random_operand(cur), 1'($urandom_range(0, 1)));
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
